### hw/rtl/ipcs_pkg.sv
// ----------------------------------------------------------------------------
// ipcs_pkg
// Shared types and constants of the IPv4 / TCP checksum engine.
// ----------------------------------------------------------------------------
package ipcs_pkg;

  typedef enum logic [1:0] {
    ModeIp   = 2'd0,
    ModeTcp  = 2'd1,
    ModeNone = 2'd2
  } mode_e;

  localparam int unsigned QueueDepthDef  = 4;
  localparam int unsigned ResultDepthDef = 4;

  localparam logic [14:0] IndexMax       = 15'h7fff;
  localparam logic [14:0] IpCheckWord    = 15'd5;
  localparam logic [14:0] AddrFirstWord  = 15'd6;
  localparam logic [14:0] AddrLastWord   = 15'd9;
  localparam logic [5:0]  TcpCheckOffset = 6'd8;
  localparam logic [16:0] ProtoTcp       = 17'd6;
  localparam logic [3:0]  IhlReset       = 4'd5;
  localparam logic [15:0] ChecksumNone   = 16'hffff;

  // One classified word on its way from the front to the accumulator.
  typedef struct packed {
    logic [16:0] addend;  // zero, the word, or twice the word
    logic [16:0] extra;   // protocol plus TCP length, used on the last word
    logic        last;
    logic        active;  // mode produces a real checksum
  } item_t;

  localparam int unsigned ItemW = $bits(item_t);

endpackage

### hw/rtl/ipcs_fifo.sv
// ----------------------------------------------------------------------------
// ipcs_fifo
// Small register-based first-in first-out queue with an occupancy count.
// ----------------------------------------------------------------------------
module ipcs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth+1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

### hw/rtl/ipcs_front.sv
// ----------------------------------------------------------------------------
// ipcs_front
// Tracks the word position and header length and classifies each word.
// ----------------------------------------------------------------------------
module ipcs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ipcs_pkg::mode_e      mode_i,
  input  logic                 accept_i,
  input  logic [15:0]          data_word_i,
  input  logic                 odd_byte_i,
  input  logic                 last_word_i,
  output ipcs_pkg::item_t      item_o
);
  import ipcs_pkg::*;

  logic [14:0] idx_q, idx_d;
  logic [3:0]  ihl_q, ihl_d;

  logic        odd_last;
  logic [15:0] word;
  logic [3:0]  ihl;
  logic [5:0]  tcp_start;
  logic [5:0]  tcp_check;
  logic        in_addr;
  logic        in_tcp;
  logic [15:0] tcp_len;

  assign odd_last  = last_word_i && odd_byte_i;
  assign word      = odd_last ? {data_word_i[15:8], 8'h00} : data_word_i;
  assign ihl       = (idx_q == '0) ? word[11:8] : ihl_q;
  assign tcp_start = {1'b0, ihl, 1'b0};
  assign tcp_check = tcp_start + TcpCheckOffset;
  assign in_addr   = (idx_q >= AddrFirstWord) && (idx_q <= AddrLastWord);
  assign in_tcp    = (idx_q >= {9'd0, tcp_start}) && (idx_q != {9'd0, tcp_check});
  // Bytes seen so far, modulo 2^16, minus the IP header bytes.
  assign tcp_len   = {idx_q, 1'b0} + 16'd2 - {15'd0, odd_last} - {10'd0, ihl, 2'b00};

  always_comb begin
    item_o.last   = last_word_i;
    item_o.addend = '0;
    item_o.extra  = '0;
    item_o.active = 1'b0;
    case (mode_i)
      ModeIp: begin
        item_o.active = 1'b1;
        if (idx_q != IpCheckWord) begin
          item_o.addend = {1'b0, word};
        end
      end
      ModeTcp: begin
        item_o.active = 1'b1;
        item_o.extra  = ProtoTcp + {1'b0, tcp_len};
        // A word in both the address range and the TCP region counts twice.
        if (in_addr && in_tcp) begin
          item_o.addend = {word, 1'b0};
        end else if (in_addr || in_tcp) begin
          item_o.addend = {1'b0, word};
        end
      end
      default: begin
        item_o.active = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    ihl_d = ihl_q;
    if (accept_i) begin
      if (last_word_i) begin
        idx_d = '0;
        ihl_d = IhlReset;
      end else begin
        idx_d = (idx_q == IndexMax) ? idx_q : idx_q + 15'd1;
        ihl_d = ihl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ihl_q <= IhlReset;
    end else begin
      idx_q <= idx_d;
      ihl_q <= ihl_d;
    end
  end

endmodule

### hw/rtl/ipcs_back.sv
// ----------------------------------------------------------------------------
// ipcs_back
// Accumulates classified words and folds the final sum into a checksum.
// ----------------------------------------------------------------------------
module ipcs_back #(
  parameter int unsigned ResultDepth = ipcs_pkg::ResultDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ipcs_pkg::item_t                  item_i,
  input  logic                             item_valid_i,
  output logic                             item_pop_o,
  input  logic [$clog2(ResultDepth+1)-1:0] res_count_i,
  output logic                             res_push_o,
  output logic [15:0]                      res_data_o
);
  import ipcs_pkg::*;

  localparam int unsigned CntW = $clog2(ResultDepth+1);
  localparam logic [CntW:0] ResultSlots = (CntW+1)'(ResultDepth);

  logic [31:0] acc_q, acc_d;
  logic [31:0] sum;
  logic [CntW:0] inflight;
  logic        room;
  logic        pop_last;

  logic        s1_valid_q;
  logic [31:0] s1_pre_q;
  logic [16:0] s1_extra_q;
  logic        s1_active_q;

  logic        s2_valid_q;
  logic [31:0] s2_total_q;
  logic        s2_active_q;

  logic [16:0] fold1;
  logic [15:0] fold2;

  // A last word may leave the queue only when the result queue is sure to
  // have a slot for it once it has passed the folding stages.
  assign inflight   = {1'b0, res_count_i} + (CntW+1)'(s1_valid_q) + (CntW+1)'(s2_valid_q);
  assign room       = inflight < ResultSlots;
  assign item_pop_o = item_valid_i && (!item_i.last || room);
  assign pop_last   = item_pop_o && item_i.last;
  assign sum        = acc_q + {15'd0, item_i.addend};

  always_comb begin
    acc_d = acc_q;
    if (item_pop_o) begin
      acc_d = item_i.last ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      s1_valid_q <= pop_last;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_last) begin
      s1_pre_q    <= sum;
      s1_extra_q  <= item_i.extra;
      s1_active_q <= item_i.active;
    end
    if (s1_valid_q) begin
      s2_total_q  <= s1_pre_q + {15'd0, s1_extra_q};
      s2_active_q <= s1_active_q;
    end
  end

  assign fold1      = {1'b0, s2_total_q[31:16]} + {1'b0, s2_total_q[15:0]};
  assign fold2      = fold1[15:0] + {15'd0, fold1[16]};
  assign res_push_o = s2_valid_q;
  assign res_data_o = s2_active_q ? ~fold2 : ChecksumNone;

`ifndef SYNTHESIS
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= ResultSlots)
    else $error("more results in flight than result slots");

  a_last_reaches_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_last |=> s1_valid_q ##1 res_push_o)
    else $error("last word did not produce a result two cycles later");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_last |=> acc_q == '0)
    else $error("accumulator not cleared after a packet");
`endif

endmodule

### hw/rtl/ip_tcp_checksum_engine.sv
// ----------------------------------------------------------------------------
// ip_tcp_checksum_engine
// Internet checksum over an IPv4 packet streamed as 16-bit words.
// ----------------------------------------------------------------------------
// Push one 16-bit packet word per cycle; the engine takes a word every cycle
// as long as full is low. The front tracks word position and IHL and tags each
// word, a small queue decouples it from the back, which adds one word per
// cycle into a 32-bit accumulator; a last word waits until the result queue
// is sure to have room. After the last word leaves the word queue, its sum
// passes the accumulate stage, then the pseudo header add; the fold into the
// result queue is combinational. The mode register selects the IPv4 header
// checksum, the TCP checksum with pseudo header, or no checksum (result
// 0xFFFF); write it only between packets, with the result queue drained.
module ip_tcp_checksum_engine #(
  parameter int unsigned QueueDepth  = ipcs_pkg::QueueDepthDef,
  parameter int unsigned ResultDepth = ipcs_pkg::ResultDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  checksum_mode_i,
  input  logic        push,
  output logic        full,
  input  logic [15:0] data_word_i,
  input  logic        odd_byte_i,
  input  logic        last_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] checksum_o
);
  import ipcs_pkg::*;

  localparam int unsigned QCntW = $clog2(QueueDepth+1);
  localparam int unsigned RCntW = $clog2(ResultDepth+1);
  localparam logic [RCntW-1:0] ResultFull = RCntW'(ResultDepth);

  mode_e            mode_q;
  logic             in_accept;
  item_t            front_item;
  item_t            back_item;
  logic [ItemW-1:0] back_item_raw;
  logic             q_empty;
  logic [QCntW-1:0] q_count;
  logic             q_pop;
  logic             res_push;
  logic [15:0]      res_data;
  logic [RCntW-1:0] res_count;
  logic             res_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIp;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= mode_e'(checksum_mode_i);
    end
  end

  assign full      = (q_count == QCntW'(QueueDepth));
  assign in_accept = push && !full;

  ipcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .accept_i    (in_accept),
    .data_word_i (data_word_i),
    .odd_byte_i  (odd_byte_i),
    .last_word_i (last_word_i),
    .item_o      (front_item)
  );

  ipcs_fifo #(
    .Width (ItemW),
    .Depth (QueueDepth)
  ) u_word_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .wdata_i (front_item),
    .pop_i   (q_pop),
    .rdata_o (back_item_raw),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  assign back_item = item_t'(back_item_raw);

  ipcs_back #(
    .ResultDepth (ResultDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_valid_i (!q_empty),
    .item_pop_o   (q_pop),
    .res_count_i  (res_count),
    .res_push_o   (res_push),
    .res_data_o   (res_data)
  );

  assign res_pop = pop && !empty;

  ipcs_fifo #(
    .Width (16),
    .Depth (ResultDepth)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_data),
    .pop_i   (res_pop),
    .rdata_o (checksum_o),
    .empty_o (empty),
    .count_o (res_count)
  );

`ifndef SYNTHESIS
  a_result_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_count != ResultFull) || res_pop)
    else $error("result pushed into a full result queue");
`endif

endmodule
